/* design/tthk_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tthk_pkg
// Shared types and constants for the text to HID keyboard report encoder.
// ----------------------------------------------------------------------------
package tthk_pkg;

    localparam int REPORT_SLOTS = 6;

    typedef enum logic [2:0] {
        OP_LOAD_ASCII = 3'd0,
        OP_LOAD_EXT   = 3'd1,
        OP_LOAD_UTF8  = 3'd2,
        OP_TYPE_CHAR  = 3'd3,
        OP_PRESS_CHAR = 3'd4,
        OP_PRESS_RAW  = 3'd5,
        OP_PRESS_MOD  = 3'd6,
        OP_RELEASE    = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ASCII_RD,
        ST_ASCII_WT,
        ST_EXT_SCAN,
        ST_UTF8_SCAN,
        ST_PRESS,
        ST_OUT1,
        ST_WAIT1,
        ST_OUT2,
        ST_WAIT2
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       ascii_rd;
        logic       scan_clr;
        logic       ext_step;
        logic       utf8_step;
        logic       set_found;
        logic       do_press;
        logic       load_out;
        logic       rel_out;
        logic       clear_held;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       ascii_hit;
        logic       ext_done;
        logic       ext_hit;
        logic       utf8_done;
        logic       utf8_hit;
        logic       found;
        logic       slot_free;
    } sts_t;

endpackage
`default_nettype wire

/* design/tthk_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tthk_datapath
// Tables, table scanning, held key state and output report register.
// ----------------------------------------------------------------------------
module tthk_datapath #(
    parameter int ASCII_DEPTH = 128,
    parameter int EXT_DEPTH   = 32,
    parameter int UTF8_DEPTH  = 64,
    parameter int KEY_SLOTS   = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire tthk_pkg::cmd_t cmd,
    output tthk_pkg::sts_t     sts,
    input  wire logic [2:0]    in_op,
    input  wire logic [31:0]   in_bytes,
    input  wire logic [6:0]    in_index,
    input  wire logic [7:0]    in_mods,
    input  wire logic [7:0]    in_key,
    input  wire logic          load_en,
    input  wire logic [7:0]    ascii_count,
    input  wire logic [5:0]    extended_count,
    input  wire logic [6:0]    utf8_count,
    output logic [67:0]        out_data
);
    localparam int AW = (ASCII_DEPTH > 1) ? $clog2(ASCII_DEPTH) : 1;
    localparam int EW = (EXT_DEPTH > 1) ? $clog2(EXT_DEPTH) : 1;
    localparam int UW = (UTF8_DEPTH > 1) ? $clog2(UTF8_DEPTH) : 1;
    localparam int REPORT_SLOTS_C = tthk_pkg::REPORT_SLOTS;

    logic [15:0] ascii_mem [ASCII_DEPTH];
    logic [23:0] ext_mem   [EXT_DEPTH];
    logic [47:0] utf8_mem  [UTF8_DEPTH];

    logic [2:0]  op_reg;
    logic [31:0] b_reg;
    logic [7:0]  rmods_reg, rkey_reg;
    logic [15:0] ascii_q_reg;
    logic [23:0] ext_q_reg;
    logic [47:0] utf8_q_reg;
    logic [8:0]  idx_reg;
    logic        qv_reg;
    logic        found_reg;
    logic [1:0]  extra_reg;
    logic [7:0]  fmods_reg, fkey_reg;
    logic [7:0]  hmods_reg;
    logic [7:0]  hkeys_reg [REPORT_SLOTS_C];
    logic [67:0] out_reg;

    logic [8:0] ascii_lim, ext_lim, utf8_lim;
    assign ascii_lim = (9'(ascii_count) < 9'(ASCII_DEPTH)) ? 9'(ascii_count) : 9'(ASCII_DEPTH);
    assign ext_lim   = (9'(extended_count) < 9'(EXT_DEPTH)) ? 9'(extended_count) : 9'(EXT_DEPTH);
    assign utf8_lim  = (9'(utf8_count) < 9'(UTF8_DEPTH)) ? 9'(utf8_count) : 9'(UTF8_DEPTH);

    always_ff @(posedge aclk) begin
        if (load_en) begin
            if (in_op == tthk_pkg::OP_LOAD_ASCII && 9'(in_index) < 9'(ASCII_DEPTH))
                ascii_mem[AW'(in_index)] <= {in_mods, in_key};
            if (in_op == tthk_pkg::OP_LOAD_EXT && 9'(in_index) < 9'(EXT_DEPTH))
                ext_mem[EW'(in_index)] <= {in_bytes[7:0], in_mods, in_key};
            if (in_op == tthk_pkg::OP_LOAD_UTF8 && 9'(in_index) < 9'(UTF8_DEPTH))
                utf8_mem[UW'(in_index)] <= {in_bytes, in_mods, in_key};
        end
        ascii_q_reg <= ascii_mem[AW'(b_reg[7:0])];
        ext_q_reg   <= ext_mem[EW'(idx_reg)];
        utf8_q_reg  <= utf8_mem[UW'(idx_reg)];
    end

    // utf8 match of registered entry
    logic [2:0] ures;
    logic       umiss;
    always_comb begin
        ures  = 3'd0;
        umiss = 1'b0;
        for (int j = 0; j < 4; j++) begin
            if (!umiss && utf8_q_reg[16+8*j +: 8] != 8'd0) begin
                if (utf8_q_reg[16+8*j +: 8] == b_reg[8*j +: 8]) ures = ures + 3'd1;
                else begin
                    umiss = 1'b1;
                    ures  = 3'd0;
                end
            end else umiss = 1'b1;
        end
    end

    logic       free_hit;
    logic [2:0] free_idx;
    always_comb begin
        free_hit = 1'b0;
        free_idx = 3'd0;
        for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
            if (hkeys_reg[i] == 8'd0) begin
                free_hit = 1'b1;
                free_idx = 3'(i);
            end
        end
    end

    assign sts.op        = op_reg;
    assign sts.ascii_hit = 9'(b_reg[7:0]) < ascii_lim;
    assign sts.ext_done  = idx_reg >= ext_lim;
    assign sts.ext_hit   = qv_reg && ext_q_reg[23:16] == b_reg[7:0];
    assign sts.utf8_done = idx_reg >= utf8_lim;
    assign sts.utf8_hit  = qv_reg && ures != 3'd0;
    assign sts.found     = found_reg;
    assign sts.slot_free = free_hit;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= in_op;
            b_reg     <= in_bytes;
            rmods_reg <= in_mods;
            rkey_reg  <= in_key;
            found_reg <= 1'b0;
            extra_reg <= 2'd0;
        end
        if (cmd.scan_clr) begin
            idx_reg <= 9'd0;
            qv_reg  <= 1'b0;
        end else if (cmd.ext_step || cmd.utf8_step) begin
            idx_reg <= idx_reg + 9'd1;
            qv_reg  <= !(cmd.ext_step ? sts.ext_done : sts.utf8_done);
        end
        if (cmd.set_found) begin
            found_reg <= 1'b1;
            if (cmd.ascii_rd) begin
                fmods_reg <= ascii_q_reg[15:8];
                fkey_reg  <= ascii_q_reg[7:0];
            end else if (cmd.ext_step) begin
                fmods_reg <= ext_q_reg[15:8];
                fkey_reg  <= ext_q_reg[7:0];
            end else begin
                fmods_reg <= utf8_q_reg[15:8];
                fkey_reg  <= utf8_q_reg[7:0];
                extra_reg <= 2'(ures - 3'd1);
            end
        end
    end

    logic [7:0] pk, pm;
    assign pk = (op_reg == tthk_pkg::OP_PRESS_RAW) ? rkey_reg : fkey_reg;
    assign pm = (op_reg == tthk_pkg::OP_PRESS_RAW) ? rmods_reg : fmods_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_held) begin
            hmods_reg <= 8'd0;
            for (int i = 0; i < REPORT_SLOTS_C; i++) hkeys_reg[i] <= 8'd0;
        end else if (cmd.do_press) begin
            if (op_reg == tthk_pkg::OP_PRESS_MOD) hmods_reg <= hmods_reg | rmods_reg;
            else if (free_hit) begin
                hmods_reg <= hmods_reg | pm;
                hkeys_reg[free_idx] <= pk;
            end
        end
    end

    // fields: mods, keys0..5, extra, matched, last
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg[7:0] <= hmods_reg;
            for (int i = 0; i < REPORT_SLOTS_C; i++) out_reg[8+8*i +: 8] <= hkeys_reg[i];
            out_reg[57:56] <= (op_reg == tthk_pkg::OP_PRESS_CHAR) ? extra_reg : 2'd0;
            out_reg[58]    <= (op_reg == tthk_pkg::OP_PRESS_CHAR ||
                               op_reg == tthk_pkg::OP_TYPE_CHAR);
            out_reg[59]    <= (op_reg != tthk_pkg::OP_TYPE_CHAR);
            out_reg[67:60] <= 8'd0;
        end else if (cmd.rel_out) begin
            out_reg[55:0]  <= 56'd0;
            out_reg[57:56] <= extra_reg;
            out_reg[58]    <= found_reg;
            out_reg[59]    <= 1'b1;
            out_reg[67:60] <= 8'd0;
        end
    end
    assign out_data = out_reg;
endmodule
`default_nettype wire

/* design/tthk_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tthk_ctrl
// Controller sequencing lookup, press and report delivery.
// ----------------------------------------------------------------------------
module tthk_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [2:0]     s_op,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire tthk_pkg::sts_t sts,
    output tthk_pkg::cmd_t      cmd
);
    tthk_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= tthk_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    logic press_op;
    assign press_op = sts.op == tthk_pkg::OP_PRESS_CHAR || sts.op == tthk_pkg::OP_TYPE_CHAR;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            tthk_pkg::ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.capture  = s_tvalid;
                cmd.scan_clr = 1'b1;
                if (s_tvalid) begin
                    if (s_op == tthk_pkg::OP_TYPE_CHAR || s_op == tthk_pkg::OP_PRESS_CHAR)
                        state_next = tthk_pkg::ST_ASCII_RD;
                    else if (s_op == tthk_pkg::OP_PRESS_RAW || s_op == tthk_pkg::OP_PRESS_MOD ||
                             s_op == tthk_pkg::OP_RELEASE)
                        state_next = tthk_pkg::ST_PRESS;
                end
            end
            tthk_pkg::ST_ASCII_RD: state_next = tthk_pkg::ST_ASCII_WT;
            tthk_pkg::ST_ASCII_WT: begin
                if (sts.ascii_hit) begin
                    cmd.ascii_rd  = 1'b1;
                    cmd.set_found = 1'b1;
                    state_next    = tthk_pkg::ST_PRESS;
                end else state_next = tthk_pkg::ST_EXT_SCAN;
            end
            tthk_pkg::ST_EXT_SCAN: begin
                cmd.ext_step = 1'b1;
                if (sts.ext_hit) begin
                    cmd.set_found = 1'b1;
                    state_next    = tthk_pkg::ST_PRESS;
                end else if (sts.ext_done) begin
                    cmd.ext_step = 1'b0;
                    cmd.scan_clr = 1'b1;
                    state_next   = tthk_pkg::ST_UTF8_SCAN;
                end
            end
            tthk_pkg::ST_UTF8_SCAN: begin
                cmd.utf8_step = 1'b1;
                if (sts.utf8_hit) begin
                    cmd.set_found = 1'b1;
                    state_next    = tthk_pkg::ST_PRESS;
                end else if (sts.utf8_done) state_next = tthk_pkg::ST_PRESS;
            end
            tthk_pkg::ST_PRESS: begin
                if (sts.op == tthk_pkg::OP_RELEASE) begin
                    cmd.clear_held = 1'b1;
                    cmd.rel_out    = 1'b1;
                    state_next     = tthk_pkg::ST_WAIT2;
                end else if (sts.op == tthk_pkg::OP_PRESS_MOD) begin
                    cmd.do_press = 1'b1;
                    state_next   = tthk_pkg::ST_OUT1;
                end else if ((press_op && !sts.found) || !sts.slot_free) begin
                    if (sts.op == tthk_pkg::OP_TYPE_CHAR) begin
                        cmd.clear_held = 1'b1;
                        cmd.rel_out    = 1'b1;
                        state_next     = tthk_pkg::ST_WAIT2;
                    end else state_next = tthk_pkg::ST_IDLE;
                end else begin
                    cmd.do_press = 1'b1;
                    state_next   = tthk_pkg::ST_OUT1;
                end
            end
            tthk_pkg::ST_OUT1: begin
                cmd.load_out = 1'b1;
                state_next   = tthk_pkg::ST_WAIT1;
            end
            tthk_pkg::ST_WAIT1: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (sts.op == tthk_pkg::OP_TYPE_CHAR) state_next = tthk_pkg::ST_OUT2;
                    else state_next = tthk_pkg::ST_IDLE;
                end
            end
            tthk_pkg::ST_OUT2: begin
                cmd.clear_held = 1'b1;
                cmd.rel_out    = 1'b1;
                state_next     = tthk_pkg::ST_WAIT2;
            end
            tthk_pkg::ST_WAIT2: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = tthk_pkg::ST_IDLE;
            end
            default: state_next = tthk_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* design/text_to_hid_keyboard_report_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_to_hid_keyboard_report_top
// Character to HID boot keyboard report encoder with loadable locale tables.
// Char ops look up the ASCII table, then scan the extended then UTF-8 table,
// one entry per cycle; a pressed type char is followed by a release report.
// One item at a time, next accepted the cycle after the last report; loads are
// written while idle and do not leave the idle state.
// Synchronous active-low reset clears counts and held keys; tables are not cleared.
// ----------------------------------------------------------------------------
module text_to_hid_keyboard_report_top #(
    parameter int ASCII_DEPTH = 128,
    parameter int EXT_DEPTH   = 32,
    parameter int UTF8_DEPTH  = 64,
    parameter int KEY_SLOTS   = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // operation, byte0, byte1, byte2, byte3, table_index, entry_modifiers, entry_key
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // report_modifiers, slot_key0..5, extra_bytes, matched
    output logic [63:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [7:0] ascii_count_reg;
    logic [5:0] ext_count_reg;
    logic [6:0] utf8_count_reg;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ascii_count_reg <= 8'd0;
            ext_count_reg   <= 6'd0;
            utf8_count_reg  <= 7'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr == 4'd0) ascii_count_reg <= pwdata[7:0];
            if (paddr == 4'd4) ext_count_reg   <= pwdata[5:0];
            if (paddr == 4'd8) utf8_count_reg  <= pwdata[6:0];
        end
    end
    always_comb begin
        case (paddr)
            4'd0:    prdata = {24'd0, ascii_count_reg};
            4'd4:    prdata = {26'd0, ext_count_reg};
            4'd8:    prdata = {25'd0, utf8_count_reg};
            default: prdata = 32'd0;
        endcase
    end

    tthk_pkg::cmd_t cmd;
    tthk_pkg::sts_t sts;
    logic [67:0]    out_data;

    tthk_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_op(s_tdata[2:0]),
        .m_tvalid, .m_tready, .sts, .cmd
    );

    tthk_datapath #(
        .ASCII_DEPTH(ASCII_DEPTH), .EXT_DEPTH(EXT_DEPTH),
        .UTF8_DEPTH(UTF8_DEPTH), .KEY_SLOTS(KEY_SLOTS)
    ) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .in_op(s_tdata[2:0]), .in_bytes(s_tdata[34:3]), .in_index(s_tdata[41:35]),
        .in_mods(s_tdata[49:42]), .in_key(s_tdata[57:50]),
        .load_en(s_tvalid && s_tready),
        .ascii_count(ascii_count_reg), .extended_count(ext_count_reg),
        .utf8_count(utf8_count_reg), .out_data
    );

    assign m_tdata = {5'd0, out_data[58:0]};
    assign m_tlast = out_data[59];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while result pending");
endmodule
`default_nettype wire
